@@ design/action_match_and_apply_core_macros.svh @@
// assertion macros shared by the action match and apply core
// expects clk_i and rst_ni in the scope of each use
`ifndef ACTION_MATCH_AND_APPLY_CORE_MACROS_SVH
`define ACTION_MATCH_AND_APPLY_CORE_MACROS_SVH

`define AMAA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`define AMAA_ASSERT_NEXT(lbl, ante, cons, msg) \
  `AMAA_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

@@ design/amaa_pkg.sv @@
// shared types and constants of the action match and apply core
// no dependencies
package amaa_pkg;

  localparam int unsigned FIELD_W = 64;
  localparam int unsigned ID_W    = 4;
  localparam int unsigned COST_W  = 16;
  localparam int unsigned CNT_W   = 5;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_EXPAND = 1'b1
  } op_e;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

@@ design/amaa_fifo.sv @@
// small register queue used for commands and for results
// depends on amaa_pkg
module amaa_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [WIDTH-1:0]       data_i,
  input  logic                   pop_i,
  output logic [WIDTH-1:0]       data_o,
  output amaa_pkg::fifo_stat_t   stat_o,
  output logic [CW-1:0]          count_o
);
  import amaa_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (count_q == CW'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign count_o      = count_q;
  assign data_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ design/amaa_front.sv @@
// front end: accepts input transactions, drops loads to missing slots,
// trims atoms and packs commands for the command queue; depends on amaa_pkg
module amaa_front #(
  parameter int unsigned MAX_ACTIONS = 16,
  parameter int unsigned NUM_ATOMS   = 64,
  parameter int unsigned CMD_W       = 1 + 4 + 4 * 64 + 16
) (
  input  logic                             push_i,
  input  amaa_pkg::fifo_stat_t             cmd_stat_i,
  input  logic                             operation_i,
  input  logic [amaa_pkg::ID_W-1:0]        entry_index_i,
  input  logic [amaa_pkg::FIELD_W-1:0]     pre_values_i,
  input  logic [amaa_pkg::FIELD_W-1:0]     pre_mask_i,
  input  logic [amaa_pkg::FIELD_W-1:0]     post_set_i,
  input  logic [amaa_pkg::FIELD_W-1:0]     post_mask_i,
  input  logic [amaa_pkg::COST_W-1:0]      entry_cost_i,
  input  logic [amaa_pkg::FIELD_W-1:0]     world_values_i,
  input  logic [amaa_pkg::FIELD_W-1:0]     world_mask_i,
  output logic                             cmd_push_o,
  output logic [CMD_W-1:0]                 cmd_data_o
);
  import amaa_pkg::*;

  typedef struct packed {
    op_e                   op;
    logic [ID_W-1:0]       slot;
    logic [NUM_ATOMS-1:0]  d0;
    logic [NUM_ATOMS-1:0]  d1;
    logic [NUM_ATOMS-1:0]  d2;
    logic [NUM_ATOMS-1:0]  d3;
    logic [COST_W-1:0]     cost;
  } cmd_t;

  cmd_t cmd;
  logic slot_ok;
  logic is_expand;

  assign is_expand = (op_e'(operation_i) == OP_EXPAND);
  assign slot_ok   = (int'(entry_index_i) < MAX_ACTIONS);

  always_comb begin
    cmd.op   = op_e'(operation_i);
    cmd.slot = entry_index_i;
    cmd.d0   = is_expand ? world_values_i[NUM_ATOMS-1:0] : pre_values_i[NUM_ATOMS-1:0];
    cmd.d1   = is_expand ? world_mask_i[NUM_ATOMS-1:0] : pre_mask_i[NUM_ATOMS-1:0];
    cmd.d2   = post_set_i[NUM_ATOMS-1:0];
    cmd.d3   = post_mask_i[NUM_ATOMS-1:0];
    cmd.cost = entry_cost_i;
  end

  // a load to a slot beyond the table is taken and dropped
  assign cmd_push_o = push_i && !cmd_stat_i.full && (is_expand || slot_ok);
  assign cmd_data_o = cmd;

endmodule

@@ design/amaa_back.sv @@
// back end: action table memory, scan sequencer, match and effect logic
// holds the action count register; depends on amaa_pkg and the macro header
`include "action_match_and_apply_core_macros.svh"

module amaa_back #(
  parameter int unsigned MAX_ACTIONS = 16,
  parameter int unsigned NUM_ATOMS   = 64,
  parameter int unsigned CMD_W       = 1 + 4 + 4 * 64 + 16,
  parameter int unsigned RES_W       = 4 + 16 + 2 * 64 + 2,
  parameter int unsigned RES_DEPTH   = 4,
  parameter int unsigned RCW         = $clog2(RES_DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [amaa_pkg::CNT_W-1:0]   cfg_data_i,
  output logic                         cfg_ready_o,
  input  logic [CMD_W-1:0]             cmd_data_i,
  input  amaa_pkg::fifo_stat_t         cmd_stat_i,
  output logic                         cmd_pop_o,
  input  amaa_pkg::fifo_stat_t         res_stat_i,
  input  logic [RCW-1:0]               res_count_i,
  output logic                         res_push_o,
  output logic [RES_W-1:0]             res_data_o
);
  import amaa_pkg::*;

  localparam int unsigned IW = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
  localparam int unsigned LW = $clog2(MAX_ACTIONS + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FLUSH = 3'b100
  } back_state_e;

  typedef struct packed {
    op_e                   op;
    logic [ID_W-1:0]       slot;
    logic [NUM_ATOMS-1:0]  d0;
    logic [NUM_ATOMS-1:0]  d1;
    logic [NUM_ATOMS-1:0]  d2;
    logic [NUM_ATOMS-1:0]  d3;
    logic [COST_W-1:0]     cost;
  } cmd_t;

  typedef struct packed {
    logic [NUM_ATOMS-1:0]  av;
    logic [NUM_ATOMS-1:0]  am;
    logic [NUM_ATOMS-1:0]  pv;
    logic [NUM_ATOMS-1:0]  pm;
    logic [COST_W-1:0]     cost;
  } entry_t;

  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [COST_W-1:0]     cost;
    logic [NUM_ATOMS-1:0]  nv;
    logic [NUM_ATOMS-1:0]  nm;
    logic                  found;
    logic                  last;
  } res_t;

  back_state_e          state_q, state_d;
  logic [CNT_W-1:0]     count_q;
  logic [LW-1:0]        limit_q, limit_d, limit_new;
  logic [LW-1:0]        rd_idx_q, rd_idx_d;
  logic                 rd_valid_q;
  logic [IW-1:0]        rd_id_q;
  logic                 hold_valid_q, hold_valid_d;
  res_t                 hold_q, cand, res;
  entry_t               tbl_q [MAX_ACTIONS];
  entry_t               rd_data_q, wr_entry;
  cmd_t                 cmd;
  logic [NUM_ATOMS-1:0] wv_q, wm_q;
  logic                 tbl_we, start_expand, rd_issue, match;

  assign cmd         = cmd_t'(cmd_data_i);
  assign cfg_ready_o = 1'b1;

  // entries beyond the table are never scanned
  assign limit_new = (int'(count_q) < MAX_ACTIONS) ? LW'(count_q) : LW'(MAX_ACTIONS);

  assign wr_entry.av   = cmd.d0;
  assign wr_entry.am   = cmd.d1;
  assign wr_entry.pv   = cmd.d2;
  assign wr_entry.pm   = cmd.d3;
  assign wr_entry.cost = cmd.cost;

  assign cmd_pop_o    = (state_q == S_IDLE) && !cmd_stat_i.empty;
  assign tbl_we       = cmd_pop_o && (cmd.op == OP_LOAD);
  assign start_expand = cmd_pop_o && (cmd.op == OP_EXPAND);

  // one read in flight per free result slot
  assign rd_issue = (state_q == S_SCAN) && (rd_idx_q < limit_q) &&
                    ((int'(res_count_i) + int'(rd_valid_q)) < RES_DEPTH);

  assign match = (((rd_data_q.av ^ wv_q) & rd_data_q.am) == '0);

  always_comb begin
    cand.id    = ID_W'(rd_id_q);
    cand.cost  = rd_data_q.cost;
    cand.nv    = (wv_q & ~rd_data_q.pm) | (rd_data_q.pv & rd_data_q.pm);
    cand.nm    = wm_q | rd_data_q.pm;
    cand.found = 1'b1;
    cand.last  = 1'b0;
  end

  // a match is held until the next one or the end of the scan decides last
  always_comb begin
    res_push_o   = 1'b0;
    res          = hold_q;
    res.last     = 1'b0;
    hold_valid_d = hold_valid_q;
    if (rd_valid_q && match) begin
      res_push_o   = hold_valid_q;
      hold_valid_d = 1'b1;
    end
    if ((state_q == S_FLUSH) && !res_stat_i.full) begin
      res_push_o   = 1'b1;
      hold_valid_d = 1'b0;
      if (hold_valid_q) begin
        res.last = 1'b1;
      end else begin
        res = '0;
        res.last = 1'b1;
      end
    end
  end

  assign res_data_o = res;

  always_comb begin
    state_d  = state_q;
    rd_idx_d = rd_idx_q;
    limit_d  = limit_q;
    case (state_q)
      S_IDLE: begin
        if (start_expand) begin
          rd_idx_d = '0;
          limit_d  = limit_new;
          state_d  = (limit_new == '0) ? S_FLUSH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_issue) begin
          rd_idx_d = rd_idx_q + LW'(1);
        end
        if ((rd_idx_q == limit_q) && !rd_valid_q) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!res_stat_i.full) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      limit_q      <= '0;
      rd_idx_q     <= '0;
      rd_valid_q   <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      limit_q      <= limit_d;
      rd_idx_q     <= rd_idx_d;
      rd_valid_q   <= rd_issue;
      hold_valid_q <= hold_valid_d;
      if (cfg_valid_i) begin
        count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_expand) begin
      wv_q <= cmd.d0;
      wm_q <= cmd.d1;
    end
    if (rd_issue) begin
      rd_id_q <= rd_idx_q[IW-1:0];
    end
    if (rd_valid_q && match) begin
      hold_q <= cand;
    end
  end

  // action table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_q[IW'(cmd.slot)] <= wr_entry;
    end
    if (rd_issue) begin
      rd_data_q <= tbl_q[rd_idx_q[IW-1:0]];
    end
  end

  `AMAA_ASSERT(a_res_room, res_push_o |-> !res_stat_i.full, "result push into full queue")
  `AMAA_ASSERT(a_read_in_scan, rd_valid_q |-> (state_q == S_SCAN), "table read outside scan")
  `AMAA_ASSERT(a_issue_bound, rd_issue |-> (rd_idx_q < limit_q), "scan read past limit")
  `AMAA_ASSERT_NEXT(a_flush_done, (state_q == S_FLUSH) && !res_stat_i.full, state_q == S_IDLE, "flush did not finish")

endmodule

@@ design/action_match_and_apply_core.sv @@
// an expansion scans the entries below limit = min(action_count, MAX_ACTIONS); its last result
// enters the result queue when the scan ends, an earlier match when the following match is read
// the back end takes one command at a time and no new one while an expansion is unfinished; the
// scan reads one table entry a cycle while the result queue has room; input is taken while the
// command queue has room. reset clears control and action_count; table contents stay undefined
module action_match_and_apply_core #(
  parameter int unsigned MAX_ACTIONS = 16,
  parameter int unsigned NUM_ATOMS   = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic                             operation_i,
  input  logic [amaa_pkg::ID_W-1:0]        entry_index_i,
  input  logic [amaa_pkg::FIELD_W-1:0]     pre_values_i,
  input  logic [amaa_pkg::FIELD_W-1:0]     pre_mask_i,
  input  logic [amaa_pkg::FIELD_W-1:0]     post_set_i,
  input  logic [amaa_pkg::FIELD_W-1:0]     post_mask_i,
  input  logic [amaa_pkg::COST_W-1:0]      entry_cost_i,
  input  logic [amaa_pkg::FIELD_W-1:0]     world_values_i,
  input  logic [amaa_pkg::FIELD_W-1:0]     world_mask_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [amaa_pkg::ID_W-1:0]        action_id_o,
  output logic [amaa_pkg::COST_W-1:0]      step_cost_o,
  output logic [amaa_pkg::FIELD_W-1:0]     next_values_o,
  output logic [amaa_pkg::FIELD_W-1:0]     next_mask_o,
  output logic                             found_o,
  output logic                             last_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [amaa_pkg::CNT_W-1:0]       cfg_data_i
);
  import amaa_pkg::*;

  localparam int unsigned CMD_W     = 1 + ID_W + 4 * NUM_ATOMS + COST_W;
  localparam int unsigned RES_W     = ID_W + COST_W + 2 * NUM_ATOMS + 2;
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned CCW       = $clog2(CMD_DEPTH + 1);
  localparam int unsigned RCW       = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [COST_W-1:0]     cost;
    logic [NUM_ATOMS-1:0]  nv;
    logic [NUM_ATOMS-1:0]  nm;
    logic                  found;
    logic                  last;
  } res_t;

  fifo_stat_t       cmd_stat, res_stat;
  logic             cmd_push, cmd_pop, res_push;
  logic [CMD_W-1:0] cmd_in, cmd_out;
  logic [RES_W-1:0] res_in, res_out;
  logic [CCW-1:0]   cmd_count;
  logic [RCW-1:0]   res_count;
  res_t             res_head;

  amaa_front #(
    .MAX_ACTIONS (MAX_ACTIONS),
    .NUM_ATOMS   (NUM_ATOMS),
    .CMD_W       (CMD_W)
  ) u_front (
    .push_i         (push),
    .cmd_stat_i     (cmd_stat),
    .operation_i    (operation_i),
    .entry_index_i  (entry_index_i),
    .pre_values_i   (pre_values_i),
    .pre_mask_i     (pre_mask_i),
    .post_set_i     (post_set_i),
    .post_mask_i    (post_mask_i),
    .entry_cost_i   (entry_cost_i),
    .world_values_i (world_values_i),
    .world_mask_i   (world_mask_i),
    .cmd_push_o     (cmd_push),
    .cmd_data_o     (cmd_in)
  );

  amaa_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH),
    .CW    (CCW)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .stat_o  (cmd_stat),
    .count_o (cmd_count)
  );

  amaa_back #(
    .MAX_ACTIONS (MAX_ACTIONS),
    .NUM_ATOMS   (NUM_ATOMS),
    .CMD_W       (CMD_W),
    .RES_W       (RES_W),
    .RES_DEPTH   (RES_DEPTH),
    .RCW         (RCW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_data_i  (cmd_out),
    .cmd_stat_i  (cmd_stat),
    .cmd_pop_o   (cmd_pop),
    .res_stat_i  (res_stat),
    .res_count_i (res_count),
    .res_push_o  (res_push),
    .res_data_o  (res_in)
  );

  amaa_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH),
    .CW    (RCW)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (pop),
    .data_o  (res_out),
    .stat_o  (res_stat),
    .count_o (res_count)
  );

  // input stalls only on a full command queue
  assign full     = cmd_stat.full || (cmd_count == CCW'(CMD_DEPTH));
  assign empty    = res_stat.empty;
  assign res_head = res_t'(res_out);

  assign action_id_o   = res_head.id;
  assign step_cost_o   = res_head.cost;
  assign next_values_o = FIELD_W'(res_head.nv);
  assign next_mask_o   = FIELD_W'(res_head.nm);
  assign found_o       = res_head.found;
  assign last_o        = res_head.last;

endmodule

@@ tb/testbench.sv @@
// testbench for action_match_and_apply_core: loads action entries and expands world states,
// predicting every successor from its own copy of the action table and checking them in order
// depends on amaa_pkg and action_match_and_apply_core
module testbench;
  import amaa_pkg::*;

  localparam int unsigned TABLE_DEPTH   = 16;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned PHASE_ITEMS   = 37;

  typedef struct packed {
    op_e                op;
    logic [ID_W-1:0]    slot;
    logic [FIELD_W-1:0] pre_v;
    logic [FIELD_W-1:0] pre_m;
    logic [FIELD_W-1:0] post_v;
    logic [FIELD_W-1:0] post_m;
    logic [COST_W-1:0]  cost;
    logic [FIELD_W-1:0] world_v;
    logic [FIELD_W-1:0] world_m;
  } rule_cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [COST_W-1:0]  cost;
    logic [FIELD_W-1:0] next_v;
    logic [FIELD_W-1:0] next_m;
    logic               found;
    logic               last;
  } successor_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               push           = 1'b0;
  logic               full;
  logic               operation_i    = 1'b0;
  logic [ID_W-1:0]    entry_index_i  = '0;
  logic [FIELD_W-1:0] pre_values_i   = '0;
  logic [FIELD_W-1:0] pre_mask_i     = '0;
  logic [FIELD_W-1:0] post_set_i     = '0;
  logic [FIELD_W-1:0] post_mask_i    = '0;
  logic [COST_W-1:0]  entry_cost_i   = '0;
  logic [FIELD_W-1:0] world_values_i = '0;
  logic [FIELD_W-1:0] world_mask_i   = '0;
  logic               empty;
  logic               pop            = 1'b0;
  logic [ID_W-1:0]    action_id_o;
  logic [COST_W-1:0]  step_cost_o;
  logic [FIELD_W-1:0] next_values_o;
  logic [FIELD_W-1:0] next_mask_o;
  logic               found_o;
  logic               last_o;
  logic               cfg_valid_i    = 1'b0;
  logic               cfg_ready_o;
  logic [CNT_W-1:0]   cfg_data_i     = '0;

  rule_cmd_t  cmd_pending_q[$];
  successor_t successor_q[$];

  logic [FIELD_W-1:0] cond_val  [TABLE_DEPTH];
  logic [FIELD_W-1:0] cond_mask [TABLE_DEPTH];
  logic [FIELD_W-1:0] eff_val   [TABLE_DEPTH];
  logic [FIELD_W-1:0] eff_mask  [TABLE_DEPTH];
  logic [COST_W-1:0]  rule_cost [TABLE_DEPTH];
  logic [FIELD_W-1:0] plan_cond_val  [TABLE_DEPTH];
  logic [FIELD_W-1:0] plan_cond_mask [TABLE_DEPTH];
  logic [CNT_W-1:0]   scan_count_cfg = '0;

  rule_cmd_t   offer;
  bit          offer_up   = 1'b0;
  int unsigned push_hold  = 0;
  int unsigned pop_hold   = 0;
  bit          push_calm  = 1'b0;
  bit          pop_calm   = 1'b0;
  successor_t  want;
  int unsigned error_count = 0;

  action_match_and_apply_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .operation_i   (operation_i),
    .entry_index_i (entry_index_i),
    .pre_values_i  (pre_values_i),
    .pre_mask_i    (pre_mask_i),
    .post_set_i    (post_set_i),
    .post_mask_i   (post_mask_i),
    .entry_cost_i  (entry_cost_i),
    .world_values_i(world_values_i),
    .world_mask_i  (world_mask_i),
    .empty         (empty),
    .pop           (pop),
    .action_id_o   (action_id_o),
    .step_cost_o   (step_cost_o),
    .next_values_o (next_values_o),
    .next_mask_o   (next_mask_o),
    .found_o       (found_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [FIELD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [FIELD_W-1:0] pick_mask();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return rand64() & rand64() & rand64();
      default: return rand64();
    endcase
  endfunction

  function automatic int unsigned draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic void check_field(string name, logic [FIELD_W-1:0] exp_v,
                                      logic [FIELD_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s expected %0h actual %0h", name, exp_v, got_v);
      error_count++;
    end
  endfunction

  task automatic predict_successors(input rule_cmd_t c);
    int unsigned scan_n;
    bit          hit_any;
    successor_t  s;
    if (c.op == OP_LOAD) begin
      cond_val[c.slot]  = c.pre_v;
      cond_mask[c.slot] = c.pre_m;
      eff_val[c.slot]   = c.post_v;
      eff_mask[c.slot]  = c.post_m;
      rule_cost[c.slot] = c.cost;
    end else begin
      scan_n  = (scan_count_cfg > TABLE_DEPTH) ? TABLE_DEPTH : scan_count_cfg;
      hit_any = 1'b0;
      for (int i = 0; i < scan_n; i++) begin
        if ((cond_val[i] & cond_mask[i]) == (c.world_v & cond_mask[i])) begin
          s.id     = ID_W'(i);
          s.cost   = rule_cost[i];
          s.next_v = (c.world_v & ~eff_mask[i]) | (eff_val[i] & eff_mask[i]);
          s.next_m = c.world_m | eff_mask[i];
          s.found  = 1'b1;
          s.last   = 1'b0;
          successor_q.push_back(s);
          hit_any  = 1'b1;
        end
      end
      if (hit_any) begin
        successor_q[$].last = 1'b1;
      end else begin
        s      = '0;
        s.last = 1'b1;
        successor_q.push_back(s);
      end
    end
  endtask

  task automatic queue_load(input logic [ID_W-1:0] slot, input logic [FIELD_W-1:0] pv,
                            input logic [FIELD_W-1:0] pm, input logic [FIELD_W-1:0] sv,
                            input logic [FIELD_W-1:0] sm, input logic [COST_W-1:0] cost);
    rule_cmd_t c;
    c.op      = OP_LOAD;
    c.slot    = slot;
    c.pre_v   = pv;
    c.pre_m   = pm;
    c.post_v  = sv;
    c.post_m  = sm;
    c.cost    = cost;
    c.world_v = rand64();
    c.world_m = rand64();
    plan_cond_val[slot]  = pv;
    plan_cond_mask[slot] = pm;
    cmd_pending_q.push_back(c);
  endtask

  task automatic queue_expand(input logic [FIELD_W-1:0] wv, input logic [FIELD_W-1:0] wm);
    rule_cmd_t c;
    c.op      = OP_EXPAND;
    c.slot    = ID_W'($urandom);
    c.pre_v   = rand64();
    c.pre_m   = rand64();
    c.post_v  = rand64();
    c.post_m  = rand64();
    c.cost    = COST_W'($urandom);
    c.world_v = wv;
    c.world_m = wm;
    cmd_pending_q.push_back(c);
  endtask

  task automatic queue_random_item();
    int unsigned        reach;
    int unsigned        pick;
    logic [COST_W-1:0]  cost;
    reach = (scan_count_cfg > TABLE_DEPTH) ? TABLE_DEPTH : scan_count_cfg;
    if ($urandom_range(0, 9) < 4) begin
      case ($urandom_range(0, 7))
        0: cost = '0;
        1: cost = '1;
        default: cost = COST_W'($urandom);
      endcase
      queue_load(ID_W'($urandom_range(0, TABLE_DEPTH - 1)), rand64(), pick_mask(), rand64(),
                 pick_mask(), cost);
    end else if (reach > 0 && $urandom_range(0, 3) != 0) begin
      pick = $urandom_range(0, reach - 1);
      queue_expand((plan_cond_val[pick] & plan_cond_mask[pick]) |
                   (rand64() & ~plan_cond_mask[pick]), pick_mask());
    end else begin
      queue_expand(rand64(), pick_mask());
    end
  endtask

  task automatic write_scan_count(input logic [CNT_W-1:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    scan_count_cfg = v;
    @(negedge clk_i);
  endtask

  task automatic wait_settled();
    do @(negedge clk_i);
    while (cmd_pending_q.size() != 0 || offer_up || successor_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_successors(offer);
        offer_up  = 1'b0;
        push_hold = draw_wait(push_calm);
      end
      if (!offer_up) begin
        if (push_hold > 0) begin
          push_hold--;
        end else if (cmd_pending_q.size() != 0) begin
          offer          = cmd_pending_q.pop_front();
          offer_up       = 1'b1;
          operation_i    <= offer.op;
          entry_index_i  <= offer.slot;
          pre_values_i   <= offer.pre_v;
          pre_mask_i     <= offer.pre_m;
          post_set_i     <= offer.post_v;
          post_mask_i    <= offer.post_m;
          entry_cost_i   <= offer.cost;
          world_values_i <= offer.world_v;
          world_mask_i   <= offer.world_m;
        end
      end
      push <= offer_up;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (successor_q.size() == 0) begin
          $error("unexpected successor transaction, action_id %0h", action_id_o);
          error_count++;
        end else begin
          want = successor_q.pop_front();
          check_field("action_id", want.id, action_id_o);
          check_field("step_cost", want.cost, step_cost_o);
          check_field("next_values", want.next_v, next_values_o);
          check_field("next_mask", want.next_m, next_mask_o);
          check_field("found", want.found, found_o);
          check_field("last", want.last, last_o);
        end
        pop_hold = draw_wait(pop_calm);
      end
      if (pop_hold > 0) begin
        pop_hold--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    logic [CNT_W-1:0] phase_counts [8];
    phase_counts = '{5'd1, 5'd17, 5'd5, 5'd0, 5'd16, 5'd31, 5'd8, 5'd3};
    phase_counts[6] = CNT_W'($urandom_range(0, 31));
    phase_counts[7] = CNT_W'($urandom_range(0, 31));
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty table after reset: nothing is scanned
    queue_expand('0, '0);
    queue_expand('1, '1);
    queue_expand(rand64(), rand64());
    wait_settled();

    // count above the table depth, all slots loaded
    write_scan_count(5'd31);
    queue_load(4'd0, '1, '0, '1, '0, '0);
    queue_load(4'd1, '0, '1, '1, '1, 16'd1);
    for (int s = 2; s < 15; s++) begin
      queue_load(ID_W'(s), rand64(), rand64(), rand64(), rand64(), COST_W'($urandom));
    end
    queue_load(4'd15, '1, '1, '0, '1, '1);
    queue_expand('0, '0);
    queue_expand('1, '1);
    queue_expand('1, '0);
    queue_expand((plan_cond_val[7] & plan_cond_mask[7]) | (rand64() & ~plan_cond_mask[7]),
                 rand64());
    queue_expand(rand64(), rand64());
    wait_settled();

    for (int p = 0; p < 8; p++) begin
      write_scan_count(phase_counts[p]);
      push_calm = ($urandom_range(0, 3) == 0);
      pop_calm  = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) queue_random_item();
      wait_settled();
    end

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/amaa_pkg.sv
design/amaa_fifo.sv
design/amaa_front.sv
design/amaa_back.sv
design/action_match_and_apply_core.sv
tb/testbench.sv
